// File: rtl/core/apsp_pkg.sv
// Shared types, codes and defaults for the Johnson all-pairs shortest path core.
package apsp_pkg;

    localparam int MAX_VERTICES_DEF = 16;
    localparam int MAX_EDGES_DEF    = 64;
    localparam int WEIGHT_BITS_DEF  = 16;
    localparam int DIST_BITS        = 24;
    localparam int VC_BITS          = 5;
    localparam logic [VC_BITS-1:0] VC_RESET = 5'd16;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_ADD   = 2'd1,
        CMD_PREP  = 2'd2,
        CMD_ROW   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_NEGCYC = 2'd2,
        ST_BAD    = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [3:0]         edge_from;
        logic [3:0]         edge_to;
        logic signed [15:0] edge_weight;
        logic [3:0]         source_vertex;
    } t_in_item;

    typedef struct packed {
        logic [1:0]                  status;
        logic [3:0]                  target_vertex;
        logic signed [DIST_BITS-1:0] distance;
        logic                        reachable;
        logic                        last;
    } t_out_item;

    function automatic t_out_item single_result(input t_status st);
        t_out_item r;
        r.status        = st;
        r.target_vertex = '0;
        r.distance      = '0;
        r.reachable     = 1'b0;
        r.last          = 1'b1;
        return r;
    endfunction

endpackage

// File: rtl/core/apsp_alu.sv
// Shared add and compare unit: sum of a, b and c less d, and whether it is below e.
module apsp_alu #(
    parameter int AB = 24
) (
    input  logic signed [AB-1:0] i_a,
    input  logic signed [AB-1:0] i_b,
    input  logic signed [AB-1:0] i_c,
    input  logic signed [AB-1:0] i_d,
    input  logic signed [AB-1:0] i_e,
    output logic signed [AB-1:0] o_sum,
    output logic                 o_lt
);
    assign o_sum = i_a + i_b + i_c - i_d;
    assign o_lt  = (o_sum < i_e);
endmodule

// File: rtl/core/all_pairs_shortest_path_johnson_core.sv
// Johnson all-pairs shortest path core. Edges are added one per transfer and
// answered with one result. Prepare runs Bellman-Ford with early exit and a
// negative cycle check: it clears the potentials, then visits each stored
// edge once per pass, at most n passes. A row runs Dijkstra with a linear
// minimum scan: for each settled vertex it scans all n vertices and then
// relaxes every stored edge, and it then emits one result per vertex; the
// single shared adder and the one-read edge table serialise this work. One item is worked at
// a time and a new item is taken only when the previous results have left.
module all_pairs_shortest_path_johnson_core #(
    parameter int MAX_VERTICES = apsp_pkg::MAX_VERTICES_DEF,
    parameter int MAX_EDGES    = apsp_pkg::MAX_EDGES_DEF,
    parameter int WEIGHT_BITS  = apsp_pkg::WEIGHT_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  apsp_pkg::t_in_item               i_in_item,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output apsp_pkg::t_out_item              o_out_item,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [apsp_pkg::VC_BITS-1:0]     i_cfg_data
);
    import apsp_pkg::*;

    localparam int VB  = $clog2(MAX_VERTICES);
    localparam int VCW = $clog2(MAX_VERTICES + 1);
    localparam int EB  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ECW = $clog2(MAX_EDGES + 1);
    localparam int AB  = WEIGHT_BITS + VB + 4;
    localparam int CB  = (AB > DIST_BITS) ? AB : DIST_BITS;
    localparam int DMAX_I = (1 << (DIST_BITS - 1)) - 1;
    localparam int DMIN_I = -(1 << (DIST_BITS - 1));

    typedef struct packed {
        logic [VB-1:0]                 tail;
        logic [VB-1:0]                 head;
        logic signed [WEIGHT_BITS-1:0] weight;
    } t_edge;

    typedef enum logic [16:0] {
        S_IDLE    = 17'h00001,
        S_RESP    = 17'h00002,
        S_BF_INIT = 17'h00004,
        S_BF_EA   = 17'h00008,
        S_BF_PA   = 17'h00010,
        S_BF_UPD  = 17'h00020,
        S_DJ_INIT = 17'h00040,
        S_DJ_HS   = 17'h00080,
        S_SC_RD   = 17'h00100,
        S_SC_CMP  = 17'h00200,
        S_DJ_PU   = 17'h00400,
        S_DJ_EA   = 17'h00800,
        S_DJ_PA   = 17'h01000,
        S_DJ_UPD  = 17'h02000,
        S_EM_RD   = 17'h04000,
        S_EM_CALC = 17'h08000,
        S_EM_OUT  = 17'h10000
    } t_state;

    t_state                   r_state;
    logic                     r_ovalid;
    t_out_item                r_out;
    logic [VC_BITS-1:0]       r_vc;
    logic [ECW-1:0]           r_total;
    logic                     r_prepared;
    logic                     r_cycle;
    logic [MAX_VERTICES-1:0]  r_reached;
    logic [MAX_VERTICES-1:0]  r_settled;
    logic [ECW-1:0]           r_ei;
    logic [VCW-1:0]           r_vi;
    logic [VCW-1:0]           r_pass;
    logic                     r_chg;
    logic                     r_check;
    logic                     r_found;
    logic [VB-1:0]            r_u;
    logic signed [AB-1:0]     r_min;
    logic signed [AB-1:0]     r_du;
    logic signed [AB-1:0]     r_hsrc;
    t_edge                    r_edge;
    logic signed [AB-1:0]     r_pa;
    logic signed [AB-1:0]     r_pb;
    logic signed [AB-1:0]     r_ra;

    t_edge                    e_mem [MAX_EDGES];
    logic signed [AB-1:0]     pot_mem [MAX_VERTICES];
    logic signed [AB-1:0]     rd_mem [MAX_VERTICES];

    logic [VCW-1:0]           n_live;
    logic [31:0]              w_raw;
    t_edge                    new_edge;
    logic                     edge_we;
    logic                     pot_we;
    logic [VB-1:0]            pot_wa;
    logic signed [AB-1:0]     pot_wd;
    logic                     rd_we;
    logic [VB-1:0]            rd_wa;
    logic signed [AB-1:0]     rd_wd;
    logic [VB-1:0]            pa_addr;
    logic [VB-1:0]            ra_addr;
    logic [VB-1:0]            vi_idx;
    logic signed [AB-1:0]     alu_a, alu_b, alu_c, alu_d, alu_e, alu_sum;
    logic                     alu_lt;
    logic signed [AB-1:0]     w_ext;
    logic                     e_live;
    logic                     viol;
    logic                     upd;
    logic                     take;
    logic                     found_now;
    logic [VB-1:0]            u_now;
    logic signed [AB-1:0]     min_now;
    logic signed [CB-1:0]     dx;
    logic signed [DIST_BITS-1:0] dclamp;
    t_out_item                row_item;
    logic                     in_acc;
    logic                     from_bad;

    always_comb begin
        if (r_vc == '0) begin
            n_live = VCW'(1);
        end else if (32'(r_vc) > MAX_VERTICES) begin
            n_live = VCW'(MAX_VERTICES);
        end else begin
            n_live = VCW'(r_vc);
        end
    end

    assign vi_idx     = r_vi[VB-1:0];
    assign in_acc     = i_in_valid && (r_state == S_IDLE);
    assign w_raw      = {16'd0, i_in_item.edge_weight};
    assign new_edge.tail   = VB'(i_in_item.edge_from);
    assign new_edge.head   = VB'(i_in_item.edge_to);
    assign new_edge.weight = w_raw[WEIGHT_BITS-1:0];
    assign from_bad   = (i_in_item.edge_from >= n_live) || (i_in_item.edge_to >= n_live);
    assign edge_we    = in_acc && (i_in_item.cmd == CMD_ADD) && !from_bad
                        && (r_total < ECW'(MAX_EDGES));

    assign w_ext  = AB'(r_edge.weight);
    assign e_live = (r_edge.tail < n_live) && (r_edge.head < n_live);

    always_comb begin
        alu_a = '0;
        alu_b = '0;
        alu_c = '0;
        alu_d = '0;
        alu_e = '0;
        case (r_state)
            S_BF_UPD: begin
                alu_a = r_pa;
                alu_b = w_ext;
                alu_e = r_pb;
            end
            S_SC_CMP: begin
                alu_a = r_ra;
                alu_e = r_min;
            end
            S_DJ_UPD: begin
                alu_a = r_du;
                alu_b = w_ext;
                alu_c = r_pa;
                alu_d = r_pb;
                alu_e = r_ra;
            end
            S_EM_CALC: begin
                alu_a = r_ra;
                alu_c = r_pa;
                alu_d = r_hsrc;
            end
            default: begin
                alu_a = '0;
            end
        endcase
    end

    apsp_alu #(.AB(AB)) u_alu (
        .i_a   (alu_a),
        .i_b   (alu_b),
        .i_c   (alu_c),
        .i_d   (alu_d),
        .i_e   (alu_e),
        .o_sum (alu_sum),
        .o_lt  (alu_lt)
    );

    assign viol      = e_live && alu_lt;
    assign upd       = e_live && (r_edge.tail == r_u)
                       && (!r_reached[r_edge.head] || alu_lt);
    assign take      = r_reached[vi_idx] && !r_settled[vi_idx] && (!r_found || alu_lt);
    assign found_now = r_found || take;
    assign u_now     = take ? vi_idx : r_u;
    assign min_now   = take ? r_ra : r_min;

    assign pot_we = (r_state == S_BF_INIT) || ((r_state == S_BF_UPD) && viol && !r_check);
    assign pot_wa = (r_state == S_BF_INIT) ? vi_idx : r_edge.head;
    assign pot_wd = (r_state == S_BF_INIT) ? '0 : alu_sum;
    assign rd_we  = (r_state == S_DJ_INIT) || ((r_state == S_DJ_UPD) && upd);
    assign rd_wa  = (r_state == S_DJ_INIT) ? vi_idx : r_edge.head;
    assign rd_wd  = (r_state == S_DJ_INIT) ? '0 : alu_sum;
    assign pa_addr = (r_state == S_BF_PA) ? r_edge.tail : vi_idx;
    assign ra_addr = (r_state == S_DJ_PA) ? r_edge.head : vi_idx;

    always_comb begin
        dx = CB'(alu_sum);
        if (dx > CB'(DMAX_I)) begin
            dclamp = DIST_BITS'(DMAX_I);
        end else if (dx < CB'(DMIN_I)) begin
            dclamp = DIST_BITS'(DMIN_I);
        end else begin
            dclamp = DIST_BITS'(dx);
        end
        row_item.status        = ST_OK;
        row_item.target_vertex = 4'(r_vi);
        row_item.reachable     = r_reached[vi_idx];
        row_item.distance      = r_reached[vi_idx] ? dclamp : '0;
        row_item.last          = ((r_vi + 1'b1) == n_live);
    end

    always_ff @(posedge i_clk) begin
        if (edge_we) begin
            e_mem[r_total[EB-1:0]] <= new_edge;
        end
        r_edge <= e_mem[r_ei[EB-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (pot_we) begin
            pot_mem[pot_wa] <= pot_wd;
        end
        r_pa <= pot_mem[pa_addr];
        r_pb <= pot_mem[r_edge.head];
    end

    always_ff @(posedge i_clk) begin
        if (rd_we) begin
            rd_mem[rd_wa] <= rd_wd;
        end
        r_ra <= rd_mem[ra_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_ovalid   <= 1'b0;
            r_vc       <= VC_RESET;
            r_total    <= '0;
            r_prepared <= 1'b0;
            r_cycle    <= 1'b0;
            r_reached  <= '0;
            r_settled  <= '0;
            r_ei       <= '0;
            r_vi       <= '0;
            r_pass     <= '0;
            r_chg      <= 1'b0;
            r_check    <= 1'b0;
            r_found    <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_ovalid <= 1'b1;
                        r_state  <= S_RESP;
                        case (i_in_item.cmd)
                            CMD_CLEAR: begin
                                r_total    <= '0;
                                r_prepared <= 1'b0;
                                r_cycle    <= 1'b0;
                                r_out      <= single_result(ST_OK);
                            end
                            CMD_ADD: begin
                                if (from_bad) begin
                                    r_out <= single_result(ST_BAD);
                                end else if (r_total >= ECW'(MAX_EDGES)) begin
                                    r_out <= single_result(ST_FULL);
                                end else begin
                                    r_total    <= r_total + 1'b1;
                                    r_prepared <= 1'b0;
                                    r_cycle    <= 1'b0;
                                    r_out      <= single_result(ST_OK);
                                end
                            end
                            CMD_PREP: begin
                                r_ovalid <= 1'b0;
                                r_vi     <= '0;
                                r_pass   <= '0;
                                r_state  <= S_BF_INIT;
                            end
                            default: begin
                                if (r_cycle) begin
                                    r_out <= single_result(ST_NEGCYC);
                                end else if (!r_prepared
                                             || (i_in_item.source_vertex >= n_live)) begin
                                    r_out <= single_result(ST_BAD);
                                end else begin
                                    r_ovalid  <= 1'b0;
                                    r_vi      <= VCW'(i_in_item.source_vertex);
                                    r_reached <= MAX_VERTICES'(1) << i_in_item.source_vertex;
                                    r_settled <= '0;
                                    r_state   <= S_DJ_INIT;
                                end
                            end
                        endcase
                    end
                end
                S_RESP: begin
                    if (i_out_ready) begin
                        r_ovalid <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                S_BF_INIT: begin
                    if ((r_vi + 1'b1) == n_live) begin
                        r_ei    <= '0;
                        r_chg   <= 1'b0;
                        r_check <= (n_live == VCW'(1));
                        if (r_total == '0) begin
                            r_prepared <= 1'b1;
                            r_cycle    <= 1'b0;
                            r_out      <= single_result(ST_OK);
                            r_ovalid   <= 1'b1;
                            r_state    <= S_RESP;
                        end else begin
                            r_state <= S_BF_EA;
                        end
                    end else begin
                        r_vi <= r_vi + 1'b1;
                    end
                end
                S_BF_EA: begin
                    r_state <= S_BF_PA;
                end
                S_BF_PA: begin
                    r_state <= S_BF_UPD;
                end
                S_BF_UPD: begin
                    if (r_check && viol) begin
                        r_prepared <= 1'b0;
                        r_cycle    <= 1'b1;
                        r_out      <= single_result(ST_NEGCYC);
                        r_ovalid   <= 1'b1;
                        r_state    <= S_RESP;
                    end else if ((r_ei + 1'b1) == r_total) begin
                        r_ei  <= '0;
                        r_chg <= 1'b0;
                        if (r_check) begin
                            r_prepared <= 1'b1;
                            r_cycle    <= 1'b0;
                            r_out      <= single_result(ST_OK);
                            r_ovalid   <= 1'b1;
                            r_state    <= S_RESP;
                        end else begin
                            if (!(r_chg || viol) || ((r_pass + 2'd2) >= n_live)) begin
                                r_check <= 1'b1;
                            end else begin
                                r_pass <= r_pass + 1'b1;
                            end
                            r_state <= S_BF_EA;
                        end
                    end else begin
                        r_ei    <= r_ei + 1'b1;
                        r_chg   <= r_chg || (viol && !r_check);
                        r_state <= S_BF_EA;
                    end
                end
                S_DJ_INIT: begin
                    r_state <= S_DJ_HS;
                end
                S_DJ_HS: begin
                    r_hsrc  <= r_pa;
                    r_vi    <= '0;
                    r_found <= 1'b0;
                    r_state <= S_SC_RD;
                end
                S_SC_RD: begin
                    r_state <= S_SC_CMP;
                end
                S_SC_CMP: begin
                    r_found <= found_now;
                    r_u     <= u_now;
                    r_min   <= min_now;
                    if ((r_vi + 1'b1) == n_live) begin
                        if (found_now) begin
                            r_settled[u_now] <= 1'b1;
                            r_du    <= min_now;
                            r_vi    <= VCW'(u_now);
                            r_state <= S_DJ_PU;
                        end else begin
                            r_vi    <= '0;
                            r_state <= S_EM_RD;
                        end
                    end else begin
                        r_vi    <= r_vi + 1'b1;
                        r_state <= S_SC_RD;
                    end
                end
                S_DJ_PU: begin
                    r_ei <= '0;
                    if (r_total == '0) begin
                        r_vi    <= '0;
                        r_found <= 1'b0;
                        r_state <= S_SC_RD;
                    end else begin
                        r_state <= S_DJ_EA;
                    end
                end
                S_DJ_EA: begin
                    r_state <= S_DJ_PA;
                end
                S_DJ_PA: begin
                    r_state <= S_DJ_UPD;
                end
                S_DJ_UPD: begin
                    if (upd) begin
                        r_reached[r_edge.head] <= 1'b1;
                    end
                    if ((r_ei + 1'b1) == r_total) begin
                        r_vi    <= '0;
                        r_found <= 1'b0;
                        r_state <= S_SC_RD;
                    end else begin
                        r_ei    <= r_ei + 1'b1;
                        r_state <= S_DJ_EA;
                    end
                end
                S_EM_RD: begin
                    r_state <= S_EM_CALC;
                end
                S_EM_CALC: begin
                    r_out    <= row_item;
                    r_ovalid <= 1'b1;
                    r_state  <= S_EM_OUT;
                end
                S_EM_OUT: begin
                    if (i_out_ready) begin
                        r_ovalid <= 1'b0;
                        if (r_out.last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_vi    <= r_vi + 1'b1;
                            r_state <= S_EM_RD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (i_cfg_valid) begin
                r_vc       <= i_cfg_data;
                r_prepared <= 1'b0;
            end
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_item  = r_out;
    assign o_cfg_ready = 1'b1;

endmodule

// File: rtl/core/apsp_chk.sv
// Port checker for the Johnson all-pairs shortest path core, with its bind.
module apsp_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input apsp_pkg::t_in_item            i_in_item,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input apsp_pkg::t_out_item           o_out_item,
    input logic                          i_cfg_valid,
    input logic                          o_cfg_ready,
    input logic [apsp_pkg::VC_BITS-1:0]  i_cfg_data
);
    import apsp_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_item)))
        else $error("result changed while stalled");

    a_busy_no_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !o_out_valid)
        else $error("result shown while taking input");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken while previous item in work");

    a_fail_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_item.status != ST_OK))
            |-> (o_out_item.last && !o_out_item.reachable))
        else $error("failed command gave more than one result");

endmodule

bind all_pairs_shortest_path_johnson_core apsp_chk u_apsp_chk (.*);
